FILE: rtl/pipt_pkg.sv
`default_nettype none

package pipt_pkg;

    localparam int COORD_WIDTH   = 21;
    localparam int FRAC_BITS     = 8;
    localparam int TOL_WIDTH     = 16;
    localparam int CFG_WIDTH     = 3 * COORD_WIDTH;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int ONE_SHIFT     = 16;
    localparam int THR_SHIFT     = 32 - 2 * FRAC_BITS;
    localparam int NSTG          = 8;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_BASE   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EDGE_A = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EDGE_B = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EDGE_C = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TOL    = 3'd4;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * COORD_WIDTH;
    localparam int N2W  = PW + 2;
    localparam int XW   = PW + 1;
    localparam int XLO  = (XW + 1) / 2;
    localparam int XHI  = XW - XLO;
    localparam int DOTW = DW + COORD_WIDTH + 2;
    localparam int TW   = DW + XW + 2;
    localparam int NLO  = N2W / 2;
    localparam int NHI  = N2W - NLO;
    localparam int TMW  = TOL_WIDTH + N2W;
    localparam int DCH  = (TW + 2) / 3;
    localparam int SPW  = ((DOTW > N2W) ? DOTW : N2W) + TOL_WIDTH + 2;
    localparam int CMPW = TOL_WIDTH + 3 * DCH + 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } pipe_ctl_t;

    typedef struct packed {
        logic [2:0][TW-1:0]   num;
        logic [TW-1:0]        det;
        logic [2:0][DOTW-1:0] dot;
        logic [2:0][N2W-1:0]  n2;
        logic [2:0][TMW-1:0]  tm;
        logic [2:0]           bnd;
    } geo_t;

    function automatic coord_t comp(input logic [CFG_WIDTH-1:0] r, input int k);
        return coord_t'(r[k*COORD_WIDTH +: COORD_WIDTH]);
    endfunction

    function automatic int next3(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pipt_ctrl.sv
`default_nettype none

module pipt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output pipt_pkg::pipe_ctl_t      ctl
);
    import pipt_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    // a stage loads when empty or when its word moves on
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NSTG-1];
    assign ctl.en    = en;
    assign ctl.vld   = vld_reg;

endmodule

`default_nettype wire

FILE: rtl/pipt_geom.sv
`default_nettype none

module pipt_geom (
    input  wire logic                                clk,
    input  wire pipt_pkg::pipe_ctl_t                 ctl,
    input  wire logic signed [pipt_pkg::COORD_WIDTH-1:0] point_x,
    input  wire logic signed [pipt_pkg::COORD_WIDTH-1:0] point_y,
    input  wire logic signed [pipt_pkg::COORD_WIDTH-1:0] point_z,
    input  wire logic [pipt_pkg::CFG_WIDTH-1:0]      base,
    input  wire logic [pipt_pkg::CFG_WIDTH-1:0]      edge_a,
    input  wire logic [pipt_pkg::CFG_WIDTH-1:0]      edge_b,
    input  wire logic [pipt_pkg::CFG_WIDTH-1:0]      edge_c,
    input  wire logic [pipt_pkg::TOL_WIDTH-1:0]      tol,
    output pipt_pkg::geo_t                           geo
);
    import pipt_pkg::*;

    coord_t e [3][3];
    coord_t p [3];
    coord_t b [3];

    // stage 1
    logic signed [DW-1:0]        d_reg [3];
    logic signed [PW-1:0]        sq_reg [3][3];
    logic signed [PW-1:0]        xa_reg [3][3];
    logic signed [PW-1:0]        xb_reg [3][3];
    logic [2*TOL_WIDTH-1:0]      thr_reg;
    logic [2*TOL_WIDTH-1:0]      tsq;
    // stage 2
    logic signed [DW-1:0]        d2_reg [3];
    logic [N2W-1:0]              n2_reg [3];
    logic signed [XW-1:0]        cross_reg [3][3];
    logic signed [DW+COORD_WIDTH-1:0] dp_reg [3][3];
    logic [2*TOL_WIDTH-1:0]      thr2_reg;
    // stage 3
    logic [2:0]                  bnd3_reg;
    logic signed [DOTW-1:0]      dot3_reg [3];
    logic [N2W-1:0]              n23_reg [3];
    logic signed [DW+XLO:0]      tlo_reg [4][3];
    logic signed [DW+XHI-1:0]    thi_reg [4][3];
    logic [TOL_WIDTH+NLO-1:0]    tml_reg [3];
    logic [TOL_WIDTH+NHI-1:0]    tmh_reg [3];
    logic signed [DW-1:0]        topd [4][3];
    logic signed [XW-1:0]        tx [4][3];
    // stage 4
    logic signed [TW-1:0]        tri_c [4];
    logic [TMW-1:0]              tm_c [3];
    geo_t                        geo_reg;

    always_comb
    begin
        p[0] = point_x;
        p[1] = point_y;
        p[2] = point_z;
        for (int i = 0; i < 3; i++)
        begin
            b[i]    = comp(base, i);
            e[0][i] = comp(edge_a, i);
            e[1][i] = comp(edge_b, i);
            e[2][i] = comp(edge_c, i);
        end
    end

    assign tsq = tol * tol;

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= DW'(p[i]) - DW'(b[i]);
            end
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[k][i] <= e[k][i] * e[k][i];
                end
            end
            // cross products b x c, c x a, a x b
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    xa_reg[j][i] <= e[next3(j)][next3(i)] * e[next3(next3(j))][next3(next3(i))];
                    xb_reg[j][i] <= e[next3(j)][next3(next3(i))] * e[next3(next3(j))][next3(i)];
                end
            end
            thr_reg <= tsq >> THR_SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                n2_reg[k] <= N2W'($unsigned(sq_reg[k][0])) + N2W'($unsigned(sq_reg[k][1]))
                           + N2W'($unsigned(sq_reg[k][2]));
                for (int i = 0; i < 3; i++)
                begin
                    cross_reg[k][i] <= XW'(xa_reg[k][i]) - XW'(xb_reg[k][i]);
                    dp_reg[k][i]    <= d_reg[i] * e[k][i];
                end
                d2_reg[k] <= d_reg[k];
            end
            thr2_reg <= thr_reg;
        end
    end

    // triple product operands: point offset against the three crosses, then edge a for det
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                topd[j][i] = (j < 3) ? d2_reg[i] : DW'(e[0][i]);
                tx[j][i]   = cross_reg[(j < 3) ? j : 0][i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                bnd3_reg[k] <= n2_reg[k] > thr2_reg;
                dot3_reg[k] <= DOTW'(dp_reg[k][0]) + DOTW'(dp_reg[k][1]) + DOTW'(dp_reg[k][2]);
                n23_reg[k]  <= n2_reg[k];
                tml_reg[k]  <= tol * n2_reg[k][NLO-1:0];
                tmh_reg[k]  <= tol * n2_reg[k][N2W-1:NLO];
            end
            for (int j = 0; j < 4; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tlo_reg[j][i] <= topd[j][i] * $signed({1'b0, tx[j][i][XLO-1:0]});
                    thi_reg[j][i] <= topd[j][i] * $signed(tx[j][i][XW-1:XLO]);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [TW-1:0] acc;
        for (int j = 0; j < 4; j++)
        begin
            acc = '0;
            for (int i = 0; i < 3; i++)
            begin
                acc = acc + (TW'(thi_reg[j][i]) <<< XLO) + TW'(tlo_reg[j][i]);
            end
            tri_c[j] = acc;
        end
        for (int k = 0; k < 3; k++)
        begin
            tm_c[k] = (TMW'(tmh_reg[k]) << NLO) + TMW'(tml_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                geo_reg.num[k] <= tri_c[k];
                geo_reg.dot[k] <= dot3_reg[k];
                geo_reg.n2[k]  <= n23_reg[k];
                geo_reg.tm[k]  <= tm_c[k];
            end
            geo_reg.det <= tri_c[3];
            geo_reg.bnd <= bnd3_reg;
        end
    end

    assign geo = geo_reg;

endmodule

`default_nettype wire

FILE: rtl/pipt_test.sv
`default_nettype none

module pipt_test (
    input  wire logic                           clk,
    input  wire pipt_pkg::pipe_ctl_t            ctl,
    input  wire logic [pipt_pkg::TOL_WIDTH-1:0] tol,
    input  wire pipt_pkg::geo_t                 geo,
    output logic                                inside_res,
    output logic [1:0]                          bounded_edges,
    output logic                                degenerate
);
    import pipt_pkg::*;

    // stage 5
    logic [2:0]               ok_c;
    logic signed [TW-1:0]     det_c;
    logic [TW-1:0]            dabs_c;
    logic signed [TW:0]       numf_c [3];
    logic [1:0]               nb5_reg;
    logic                     span5_reg;
    logic                     zero5_reg;
    logic [TW-1:0]            dabs5_reg;
    logic signed [TW:0]       numf5_reg [3];
    // stage 6
    logic [3*DCH-1:0]         dabsx;
    logic [TOL_WIDTH+DCH-1:0] pp6_reg [3];
    logic [TW-1:0]            dabs6_reg;
    logic signed [TW:0]       numf6_reg [3];
    logic [1:0]               nb6_reg;
    logic                     span6_reg;
    logic                     zero6_reg;
    // stage 7
    logic signed [CMPW-1:0]   prod_c;
    logic signed [CMPW-1:0]   lo7_reg;
    logic signed [CMPW-1:0]   hi7_reg;
    logic signed [CMPW-1:0]   nsc7_reg [3];
    logic [1:0]               nb7_reg;
    logic                     span7_reg;
    logic                     zero7_reg;
    // stage 8
    logic                     coef_c;
    logic                     inside_next;
    logic                     inside_reg;
    logic [1:0]               nb_reg;
    logic                     degen_reg;

    always_comb
    begin
        logic signed [SPW-1:0] dps;
        logic signed [SPW-1:0] tms;
        logic signed [SPW-1:0] hi;
        for (int k = 0; k < 3; k++)
        begin
            dps     = SPW'($signed(geo.dot[k])) <<< ONE_SHIFT;
            tms     = $signed(SPW'(geo.tm[k]));
            hi      = $signed(SPW'(geo.n2[k]) << ONE_SHIFT) + tms;
            ok_c[k] = (-tms <= dps) && (dps <= hi);
        end
        det_c  = $signed(geo.det);
        dabs_c = det_c[TW-1] ? $unsigned(-det_c) : $unsigned(det_c);
        for (int j = 0; j < 3; j++)
        begin
            numf_c[j] = det_c[TW-1] ? -(TW+1)'($signed(geo.num[j]))
                                    : (TW+1)'($signed(geo.num[j]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[4])
        begin
            nb5_reg   <= 2'(geo.bnd[0]) + 2'(geo.bnd[1]) + 2'(geo.bnd[2]);
            span5_reg <= &(ok_c | ~geo.bnd);
            zero5_reg <= (geo.det == '0);
            dabs5_reg <= dabs_c;
            for (int j = 0; j < 3; j++)
            begin
                numf5_reg[j] <= numf_c[j];
            end
        end
    end

    assign dabsx = (3*DCH)'(dabs5_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.en[5])
        begin
            for (int c = 0; c < 3; c++)
            begin
                pp6_reg[c]   <= tol * dabsx[c*DCH +: DCH];
                numf6_reg[c] <= numf5_reg[c];
            end
            dabs6_reg <= dabs5_reg;
            nb6_reg   <= nb5_reg;
            span6_reg <= span5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    always_comb
    begin
        prod_c = '0;
        for (int c = 0; c < 3; c++)
        begin
            prod_c = prod_c + $signed(CMPW'(pp6_reg[c]) << (c * DCH));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[6])
        begin
            lo7_reg <= -prod_c;
            hi7_reg <= $signed(CMPW'(dabs6_reg) << ONE_SHIFT) + prod_c;
            for (int j = 0; j < 3; j++)
            begin
                nsc7_reg[j] <= CMPW'(numf6_reg[j]) <<< ONE_SHIFT;
            end
            nb7_reg   <= nb6_reg;
            span7_reg <= span6_reg;
            zero7_reg <= zero6_reg;
        end
    end

    always_comb
    begin
        coef_c = 1'b1;
        for (int j = 0; j < 3; j++)
        begin
            if (!((lo7_reg <= nsc7_reg[j]) && (nsc7_reg[j] <= hi7_reg)))
            begin
                coef_c = 1'b0;
            end
        end
        if (nb7_reg == 2'd0)
        begin
            inside_next = 1'b1;
        end
        else if (nb7_reg != 2'd3)
        begin
            inside_next = span7_reg;
        end
        else
        begin
            inside_next = !zero7_reg && coef_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[7])
        begin
            inside_reg <= inside_next;
            nb_reg     <= nb7_reg;
            degen_reg  <= (nb7_reg == 2'd3) && zero7_reg;
        end
    end

    assign inside_res    = inside_reg;
    assign bounded_edges = nb_reg;
    assign degenerate    = degen_reg;

endmodule

`default_nettype wire

FILE: rtl/point_in_parallelepiped_test.sv
`default_nettype none

// channel   handshake             payload
// input     in_valid / in_stall   point_x, point_y, point_z
// output    out_valid / out_stall inside_res, bounded_edges, degenerate
// config    cfg_wr_en             cfg_index, cfg_data
//
// eight register stages; one word per cycle while the output is not stalled
// every word takes the same path
// reset clears the stage valid bits and the configuration registers
// a stalled output holds; empty stages still fill behind it

module point_in_parallelepiped_test (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [pipt_pkg::COORD_WIDTH-1:0] point_x,
    input  wire logic signed [pipt_pkg::COORD_WIDTH-1:0] point_y,
    input  wire logic signed [pipt_pkg::COORD_WIDTH-1:0] point_z,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      inside_res,
    output logic [1:0]                                bounded_edges,
    output logic                                      degenerate,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [pipt_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  wire logic [pipt_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import pipt_pkg::*;

    logic [CFG_WIDTH-1:0] base_reg;
    logic [CFG_WIDTH-1:0] edge_a_reg;
    logic [CFG_WIDTH-1:0] edge_b_reg;
    logic [CFG_WIDTH-1:0] edge_c_reg;
    logic [TOL_WIDTH-1:0] tol_reg;
    pipe_ctl_t            ctl;
    geo_t                 geo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            edge_a_reg <= '0;
            edge_b_reg <= '0;
            edge_c_reg <= '0;
            tol_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BASE:   base_reg   <= cfg_data;
                REG_EDGE_A: edge_a_reg <= cfg_data;
                REG_EDGE_B: edge_b_reg <= cfg_data;
                REG_EDGE_C: edge_c_reg <= cfg_data;
                REG_TOL:    tol_reg    <= cfg_data[TOL_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    pipt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    pipt_geom u_geom (
        .clk     (clk),
        .ctl     (ctl),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .base    (base_reg),
        .edge_a  (edge_a_reg),
        .edge_b  (edge_b_reg),
        .edge_c  (edge_c_reg),
        .tol     (tol_reg),
        .geo     (geo)
    );

    pipt_test u_test (
        .clk           (clk),
        .ctl           (ctl),
        .tol           (tol_reg),
        .geo           (geo),
        .inside_res    (inside_res),
        .bounded_edges (bounded_edges),
        .degenerate    (degenerate)
    );

endmodule

`default_nettype wire

FILE: dv/pipt_checker.sv
module pipt_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic [pipt_pkg::COORD_WIDTH-1:0]   point_x,
    input  wire logic [pipt_pkg::COORD_WIDTH-1:0]   point_y,
    input  wire logic [pipt_pkg::COORD_WIDTH-1:0]   point_z,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic                               inside_res,
    input  wire logic [1:0]                         bounded_edges,
    input  wire logic                               degenerate,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pipt_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [pipt_pkg::CFG_WIDTH-1:0]     cfg_data,
    output int                                      mismatches,
    output int                                      outstanding
);
    import pipt_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] edges;
        logic       degen;
    } verdict_t;

    verdict_t             verdict_q[$];
    logic [CFG_WIDTH-1:0] base_r;
    logic [CFG_WIDTH-1:0] edge_r [3];
    logic [TOL_WIDTH-1:0] tol_r;

    function automatic longint component(input logic [CFG_WIDTH-1:0] r, input int k);
        logic signed [COORD_WIDTH-1:0] c;
        longint v;
        c = r[k*COORD_WIDTH +: COORD_WIDTH];
        v = c;
        return v;
    endfunction

    function automatic longint dot(input longint p [3], input longint q [3]);
        return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function automatic bit within_span(input longint d [3], input longint v [3],
                                       input longint tol);
        longint dp;
        longint m2;
        dp = dot(d, v) * 65536;
        m2 = dot(v, v);
        return dp >= -(tol * m2) && dp <= (65536 + tol) * m2;
    endfunction

    // p . (q x r), kept wide
    function automatic wide_t box_product(input longint p [3], input longint q [3],
                                          input longint r [3]);
        wide_t c0, c1, c2, p0, p1, p2;
        c0 = q[1] * r[2] - q[2] * r[1];
        c1 = q[2] * r[0] - q[0] * r[2];
        c2 = q[0] * r[1] - q[1] * r[0];
        p0 = p[0];
        p1 = p[1];
        p2 = p[2];
        return p0 * c0 + p1 * c1 + p2 * c2;
    endfunction

    function automatic bit coef_in_range(input wide_t num, input wide_t det,
                                         input longint tol);
        wide_t s, lo, hi, t;
        t  = tol;
        s  = num * 65536;
        lo = -(t * det);
        hi = (t + 65536) * det;
        return lo <= s && s <= hi;
    endfunction

    function automatic verdict_t classify(input logic [COORD_WIDTH-1:0] px,
                                          input logic [COORD_WIDTH-1:0] py,
                                          input logic [COORD_WIDTH-1:0] pz);
        longint   b [3];
        longint   e0 [3];
        longint   e1 [3];
        longint   e2 [3];
        longint   d [3];
        logic [COORD_WIDTH*3-1:0] pr;
        longint   tol;
        longint   thr;
        bit [2:0] bnd;
        int       nb;
        wide_t    det, s, t, u;
        verdict_t v;
        pr  = {pz, py, px};
        tol = tol_r;
        thr = (tol * tol) >>> THR_SHIFT;
        for (int k = 0; k < 3; k++)
        begin
            b[k]  = component(base_r, k);
            e0[k] = component(edge_r[0], k);
            e1[k] = component(edge_r[1], k);
            e2[k] = component(edge_r[2], k);
            d[k]  = component(pr, k) - b[k];
        end
        bnd[0] = dot(e0, e0) > thr;
        bnd[1] = dot(e1, e1) > thr;
        bnd[2] = dot(e2, e2) > thr;
        nb = int'(bnd[0]) + int'(bnd[1]) + int'(bnd[2]);
        v.edges = nb[1:0];
        v.degen = 1'b0;
        v.hit = 1'b1;
        if (nb == 3)
        begin
            det = box_product(e0, e1, e2);
            if (det == 0)
            begin
                v.degen = 1'b1;
                v.hit = 1'b0;
            end
            else
            begin
                s = box_product(d, e1, e2);
                t = box_product(e0, d, e2);
                u = box_product(e0, e1, d);
                if (det < 0)
                begin
                    det = -det;
                    s = -s;
                    t = -t;
                    u = -u;
                end
                v.hit = coef_in_range(s, det, tol) && coef_in_range(t, det, tol)
                        && coef_in_range(u, det, tol);
            end
        end
        else
        begin
            if (bnd[0] && !within_span(d, e0, tol)) v.hit = 1'b0;
            if (bnd[1] && !within_span(d, e1, tol)) v.hit = 1'b0;
            if (bnd[2] && !within_span(d, e2, tol)) v.hit = 1'b0;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            base_r <= '0;
            edge_r[0] <= '0;
            edge_r[1] <= '0;
            edge_r[2] <= '0;
            tol_r <= '0;
            verdict_q.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BASE:   base_r <= cfg_data;
                    REG_EDGE_A: edge_r[0] <= cfg_data;
                    REG_EDGE_B: edge_r[1] <= cfg_data;
                    REG_EDGE_C: edge_r[2] <= cfg_data;
                    REG_TOL:    tol_r <= cfg_data[TOL_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                verdict_q.push_back(classify(point_x, point_y, point_z));
            if (out_valid && !out_stall)
            begin
                got = '{inside_res, bounded_edges, degenerate};
                if (verdict_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected word: inside=%0d edges=%0d degen=%0d",
                                 got.hit, got.edges, got.degen);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (want != got)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: expected inside=%0d edges=%0d degen=%0d,",
                                      " got inside=%0d edges=%0d degen=%0d"},
                                     want.hit, want.edges, want.degen,
                                     got.hit, got.edges, got.degen);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= verdict_q.size();
        end
    end

endmodule

FILE: dv/tb_point_in_parallelepiped_test.sv
module tb_point_in_parallelepiped_test;
    import pipt_pkg::*;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 3'd5;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam longint CMAX = 1048575;
    localparam longint CMIN = -1048576;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [COORD_WIDTH-1:0]   point_x = '0;
    logic [COORD_WIDTH-1:0]   point_y = '0;
    logic [COORD_WIDTH-1:0]   point_z = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     inside_res;
    logic [1:0]               bounded_edges;
    logic                     degenerate;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]     cfg_data = '0;
    int                       mismatches;
    int                       outstanding;
    int                       stall_pct = 0;
    int                       stall_left = 0;
    int                       idle_cycles = 0;

    longint base_v [3];
    longint edge_v [3][3];

    point_in_parallelepiped_test u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .inside_res(inside_res), .bounded_edges(bounded_edges), .degenerate(degenerate),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pipt_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .inside_res(inside_res), .bounded_edges(bounded_edges), .degenerate(degenerate),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
                stall_left = $urandom_range(20, 300);
            end
            stall_left--;
            out_stall <= $urandom_range(0, 99) < stall_pct;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_point_in_parallelepiped_test failed");
            $finish;
        end
    end

    function automatic longint clip(input longint v);
        return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pack3(input longint v [3]);
        return {v[2][COORD_WIDTH-1:0], v[1][COORD_WIDTH-1:0], v[0][COORD_WIDTH-1:0]};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_point(input longint x, input longint y, input longint z,
                              input bit steady);
        int gap;
        in_valid <= 1'b1;
        point_x <= x[COORD_WIDTH-1:0];
        point_y <= y[COORD_WIDTH-1:0];
        point_z <= z[COORD_WIDTH-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain the pipeline before touching the registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_block(input longint tol);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BASE;
        cfg_data <= pack3(base_v);
        @(posedge clk);
        cfg_index <= REG_EDGE_A;
        cfg_data <= pack3(edge_v[0]);
        @(posedge clk);
        cfg_index <= REG_EDGE_B;
        cfg_data <= pack3(edge_v[1]);
        @(posedge clk);
        cfg_index <= REG_EDGE_C;
        cfg_data <= pack3(edge_v[2]);
        @(posedge clk);
        cfg_index <= REG_TOL;
        cfg_data <= CFG_WIDTH'({$urandom, $urandom}) & ~63'hFFFF | 63'(tol);
        @(posedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_index <= REG_SPARE;
            cfg_data <= CFG_WIDTH'({$urandom, $urandom});
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_vec(output longint v [3], input longint x, input longint y,
                           input longint z);
        v[0] = x;
        v[1] = y;
        v[2] = z;
    endtask

    function automatic longint rnd_signed(input int mag);
        return longint'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    task automatic make_edge(input int k, input bit bounded, input bit huge, input longint tol);
        int lim;
        if (!bounded)
        begin
            lim = int'(tol >> 9);
            for (int j = 0; j < 3; j++)
                edge_v[k][j] = (lim == 0) ? 0 : rnd_signed(lim);
        end
        else if (huge)
        begin
            for (int j = 0; j < 3; j++)
                edge_v[k][j] = longint'($urandom_range(0, 2097151)) + CMIN;
            edge_v[k][$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
        end
        else
        begin
            for (int j = 0; j < 3; j++)
                edge_v[k][j] = rnd_signed(4000);
            edge_v[k][$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0)
                ? longint'($urandom_range(300, 20000)) : -longint'($urandom_range(300, 20000));
        end
    endtask

    task automatic send_near(input bit steady);
        longint p [3];
        longint f [3];
        int     r;
        r = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++)
            f[k] = (r < 15) ? 256 * $urandom_range(0, 1) : longint'($urandom_range(0, 384)) - 64;
        for (int j = 0; j < 3; j++)
        begin
            p[j] = base_v[j] + ((f[0] * edge_v[0][j] + f[1] * edge_v[1][j]
                                 + f[2] * edge_v[2][j]) >>> 8);
            if (r >= 80)
                p[j] = longint'($urandom_range(0, 2097151)) + CMIN;
            else if (r >= 70)
                p[j] = p[j] + rnd_signed(3);
            p[j] = clip(p[j]);
        end
        send_point(p[0], p[1], p[2], steady);
    endtask

    task automatic random_phase(input int count);
        longint tol;
        int     nb;
        int     first;
        bit     huge;
        bit     steady;
        case ($urandom_range(0, 4))
            0: tol = 0;
            1: tol = 65535;
            2: tol = $urandom_range(0, 255);
            default: tol = $urandom_range(0, 65535);
        endcase
        nb = $urandom_range(0, 3);
        first = $urandom_range(0, 2);
        huge = $urandom_range(0, 5) == 0;
        steady = $urandom_range(0, 4) == 0;
        for (int k = 0; k < 3; k++)
            make_edge((first + k) % 3, k < nb, huge, tol);
        if (nb == 3 && $urandom_range(0, 4) == 0)
        begin
            for (int j = 0; j < 3; j++)
                edge_v[2][j] = clip(edge_v[0][j] + edge_v[1][j]);
        end
        for (int j = 0; j < 3; j++)
            base_v[j] = huge ? longint'($urandom_range(0, 2097151)) + CMIN : rnd_signed(30000);
        load_block(tol);
        for (int i = 0; i < count; i++)
            send_near(steady);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: nothing bounded, everything inside
        send_point(CMAX, CMAX, CMAX, 1'b0);
        send_point(CMIN, CMIN, CMIN, 1'b0);
        send_point(0, 0, 0, 1'b0);

        // axis-aligned cube, zero slack, faces and just beyond
        set_vec(base_v, 0, 0, 0);
        set_vec(edge_v[0], 256, 0, 0);
        set_vec(edge_v[1], 0, 256, 0);
        set_vec(edge_v[2], 0, 0, 256);
        load_block(0);
        send_point(128, 128, 128, 1'b0);
        send_point(0, 0, 0, 1'b0);
        send_point(256, 256, 256, 1'b0);
        send_point(257, 128, 128, 1'b0);
        send_point(-1, 128, 128, 1'b0);
        send_point(128, 128, 300, 1'b0);

        // edges at the length threshold: one just bounded, two just unbounded
        set_vec(edge_v[0], 256, 0, 0);
        set_vec(edge_v[1], 0, 255, 0);
        set_vec(edge_v[2], 0, 0, -255);
        load_block(65535);
        send_point(512, 9000, -9000, 1'b0);
        send_point(513, 0, 0, 1'b0);
        send_point(-256, 0, 0, 1'b0);

        // flat block with a zero determinant
        set_vec(edge_v[2], 256, 255, 0);
        set_vec(edge_v[1], 0, 256, 0);
        load_block(100);
        send_point(10, 10, 0, 1'b0);
        send_point(CMAX, CMIN, 5, 1'b0);

        // full-scale edges and corner
        set_vec(base_v, CMIN, CMAX, CMIN);
        set_vec(edge_v[0], CMAX, CMIN, CMAX);
        set_vec(edge_v[1], CMIN, CMIN, CMAX);
        set_vec(edge_v[2], CMAX, CMAX, CMIN);
        load_block(65535);
        send_point(CMIN, CMAX, CMIN, 1'b0);
        send_point(CMAX, CMIN, CMAX, 1'b0);
        send_point(0, 0, 0, 1'b0);
        send_point(-1, -1, -1, 1'b0);

        for (int ph = 0; ph < 20; ph++)
            random_phase(90);

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_point_in_parallelepiped_test passed");
        else
            $display("tb_point_in_parallelepiped_test failed");
        $finish;
    end

endmodule

FILE: point_in_parallelepiped_test.f
rtl/pipt_pkg.sv
rtl/pipt_ctrl.sv
rtl/pipt_geom.sv
rtl/pipt_test.sv
rtl/point_in_parallelepiped_test.sv
dv/pipt_checker.sv
dv/tb_point_in_parallelepiped_test.sv
